/* rtl/m65x_pkg.sv */
// Package for the 6502 instruction executor: opcodes, payload structs and queue entry.
// Depends on nothing; used by every module of the block.
package m65x_pkg;

   localparam int MemAddrBitsDefault = 16;
   localparam int QueueDepth = 2;

   typedef enum logic [5:0] {
      OP_LDA = 6'd0,  OP_LDX = 6'd1,  OP_LDY = 6'd2,  OP_STA = 6'd3,
      OP_STX = 6'd4,  OP_STY = 6'd5,  OP_TAX = 6'd6,  OP_TAY = 6'd7,
      OP_TXA = 6'd8,  OP_TYA = 6'd9,  OP_TSX = 6'd10, OP_TXS = 6'd11,
      OP_PHA = 6'd12, OP_PHP = 6'd13, OP_PLA = 6'd14, OP_PLP = 6'd15,
      OP_AND = 6'd16, OP_EOR = 6'd17, OP_ORA = 6'd18, OP_BIT = 6'd19,
      OP_ADC = 6'd20, OP_SBC = 6'd21, OP_CMP = 6'd22, OP_CPX = 6'd23,
      OP_CPY = 6'd24, OP_INC = 6'd25, OP_INX = 6'd26, OP_INY = 6'd27,
      OP_DEC = 6'd28, OP_DEX = 6'd29, OP_DEY = 6'd30, OP_ASL = 6'd31,
      OP_LSR = 6'd32, OP_ROL = 6'd33, OP_ROR = 6'd34, OP_BRK = 6'd35,
      OP_NOP = 6'd36, OP_RTI = 6'd37, OP_JMP = 6'd38, OP_JSR = 6'd39,
      OP_RTS = 6'd40, OP_BCC = 6'd41, OP_BCS = 6'd42, OP_BEQ = 6'd43,
      OP_BMI = 6'd44, OP_BNE = 6'd45, OP_BPL = 6'd46, OP_BVC = 6'd47,
      OP_BVS = 6'd48, OP_CLC = 6'd49, OP_CLD = 6'd50, OP_CLI = 6'd51,
      OP_CLV = 6'd52, OP_SEC = 6'd53, OP_SED = 6'd54, OP_SEI = 6'd55,
      OP_HOST_LOAD = 6'd56
   } op_type;

   // Memory traffic classes, set by the front end.
   typedef enum logic [2:0] {
      CL_NONE, CL_READ, CL_WRITE, CL_RMW, CL_PUSH, CL_PULL
   } class_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RD1, ST_RD2, ST_RD3, ST_WR1, ST_WR2, ST_WR3, ST_DONE
   } state_type;

   typedef struct packed {
      logic [5:0]  req_type;
      logic [15:0] operand;
      logic        on_accumulator;
      logic [15:0] current_pc;
      logic [7:0]  load_data;
   } req_type_s_type;

   typedef struct packed {
      logic [7:0]  acc;
      logic [7:0]  x_reg;
      logic [7:0]  y_reg;
      logic [7:0]  status;
      logic [7:0]  stack_ptr;
      logic [15:0] next_pc;
      logic        extra_cycle;
      logic        branch_taken;
   } rsp_type;

   typedef struct packed {
      req_type_s_type req;
      class_type      cls;
      logic [1:0]     beats;   // number of memory beats: 0..3
   } entry_type;

endpackage

/* rtl/m65x_front.sv */
// Front end: accepts instruction beats, classifies memory traffic, holds a short queue.
// Depends on m65x_pkg.
module m65x_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  m65x_pkg::req_type_s_type   req_data,
   output logic                       q_valid,
   input  logic                       q_ready,
   output m65x_pkg::entry_type        q_data
);
   import m65x_pkg::*;

   entry_type  slot_ff [QueueDepth];
   entry_type  slot_in;
   logic [$clog2(QueueDepth+1)-1:0] count_ff, count_in;
   logic [$clog2(QueueDepth)-1:0]   rd_ff, wr_ff;
   logic push, pop;

   always_comb begin
      slot_in.req = req_data;
      slot_in.cls = CL_NONE;
      slot_in.beats = 2'd0;
      priority case (1'b1)
         req_data.req_type == OP_LDA || req_data.req_type == OP_LDX ||
         req_data.req_type == OP_LDY || (req_data.req_type >= OP_AND &&
         req_data.req_type <= OP_CPY): begin
            slot_in.cls = CL_READ; slot_in.beats = 2'd1;
         end
         req_data.req_type == OP_STA || req_data.req_type == OP_STX ||
         req_data.req_type == OP_STY || req_data.req_type == OP_HOST_LOAD: begin
            slot_in.cls = CL_WRITE; slot_in.beats = 2'd1;
         end
         req_data.req_type == OP_INC || req_data.req_type == OP_DEC ||
         ((req_data.req_type >= OP_ASL && req_data.req_type <= OP_ROR) &&
          !req_data.on_accumulator): begin
            slot_in.cls = CL_RMW; slot_in.beats = 2'd1;
         end
         req_data.req_type == OP_PHA || req_data.req_type == OP_PHP: begin
            slot_in.cls = CL_PUSH; slot_in.beats = 2'd1;
         end
         req_data.req_type == OP_JSR: begin
            slot_in.cls = CL_PUSH; slot_in.beats = 2'd2;
         end
         req_data.req_type == OP_BRK: begin
            slot_in.cls = CL_PUSH; slot_in.beats = 2'd3;
         end
         req_data.req_type == OP_PLA || req_data.req_type == OP_PLP: begin
            slot_in.cls = CL_PULL; slot_in.beats = 2'd1;
         end
         req_data.req_type == OP_RTS: begin
            slot_in.cls = CL_PULL; slot_in.beats = 2'd2;
         end
         req_data.req_type == OP_RTI: begin
            slot_in.cls = CL_PULL; slot_in.beats = 2'd3;
         end
         default: ;
      endcase
   end

   assign req_ready = (count_ff != QueueDepth[$clog2(QueueDepth+1)-1:0]);
   assign push = req_valid && req_ready;
   assign q_valid = (count_ff != '0);
   assign pop = q_valid && q_ready;
   assign q_data = slot_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff <= '0;
         wr_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
      end
      if (push) slot_ff[wr_ff] <= slot_in;
   end
endmodule

/* rtl/m65x_back.sv */
// Back end: register file, single-port byte memory and the sequencer that runs each entry.
// Depends on m65x_pkg.
module m65x_back #(
   parameter int MEM_ADDR_BITS = m65x_pkg::MemAddrBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  m65x_pkg::entry_type   q_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output m65x_pkg::rsp_type     rsp_data
);
   import m65x_pkg::*;

   logic [7:0] mem [2**MEM_ADDR_BITS];
   logic [7:0] rdata_ff;

   state_type state_ff, state_in;
   entry_type cur_ff;
   logic [7:0] a_ff, a_in, x_ff, x_in, y_ff, y_in, s_ff, s_in, p_ff, p_in;
   logic [7:0] b1_ff, b1_in, b2_ff, b2_in;
   rsp_type    out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   logic       take;

   logic                     mem_re, mem_we;
   logic [MEM_ADDR_BITS-1:0] mem_addr;
   logic [7:0]               mem_wd;

   logic [7:0] m, res, sum_b;
   logic [8:0] sum;
   logic [15:0] ret, npc;
   logic extra, taken, cond;
   logic [5:0] op;

   assign op = cur_ff.req.req_type;
   assign q_ready = (state_ff == ST_IDLE);
   assign take = q_valid && q_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (take) begin
            unique case (q_data.cls)
               CL_READ, CL_RMW, CL_PULL: state_in = ST_RD1;
               CL_WRITE, CL_PUSH:        state_in = ST_WR1;
               default:                  state_in = ST_DONE;
            endcase
         end
         ST_RD1: state_in = (cur_ff.beats > 2'd1 && cur_ff.cls == CL_PULL) ? ST_RD2 : ST_DONE;
         ST_RD2: state_in = (cur_ff.beats > 2'd2) ? ST_RD3 : ST_DONE;
         ST_RD3: state_in = ST_DONE;
         ST_WR1: state_in = (cur_ff.beats > 2'd1) ? ST_WR2 : ST_DONE;
         ST_WR2: state_in = (cur_ff.beats > 2'd2) ? ST_WR3 : ST_DONE;
         ST_WR3: state_in = ST_DONE;
         ST_DONE: if (!out_valid_ff || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory port control; read data comes back through a register in the following cycle.
   always_comb begin
      mem_re = 1'b0;
      mem_we = 1'b0;
      mem_addr = cur_ff.req.operand[MEM_ADDR_BITS-1:0];
      mem_wd = 8'h00;
      ret = (op == OP_BRK) ? cur_ff.req.current_pc + 16'd2 : cur_ff.req.current_pc - 16'd1;
      unique case (state_ff)
         ST_IDLE: if (take) begin
            mem_addr = q_data.req.operand[MEM_ADDR_BITS-1:0];
            if (q_data.cls == CL_READ || q_data.cls == CL_RMW) mem_re = 1'b1;
            if (q_data.cls == CL_PULL) begin
               mem_re = 1'b1;
               mem_addr = MEM_ADDR_BITS'({8'h01, s_ff + 8'd1});
            end
         end
         // Only fetch another stack byte when the pull has one left.
         ST_RD1, ST_RD2: if (cur_ff.cls == CL_PULL && state_in != ST_DONE) begin
            mem_re = 1'b1;
            mem_addr = MEM_ADDR_BITS'({8'h01, s_ff + 8'd1});
         end
         ST_WR1: begin
            mem_we = 1'b1;
            if (cur_ff.cls == CL_PUSH) mem_addr = MEM_ADDR_BITS'({8'h01, s_ff});
            unique case (op)
               OP_STA, OP_PHA: mem_wd = a_ff;
               OP_STX: mem_wd = x_ff;
               OP_STY: mem_wd = y_ff;
               OP_PHP: mem_wd = p_ff;
               OP_HOST_LOAD: mem_wd = cur_ff.req.load_data;
               default: mem_wd = ret[15:8];
            endcase
         end
         ST_WR2: begin
            mem_we = 1'b1;
            mem_addr = MEM_ADDR_BITS'({8'h01, s_ff});
            mem_wd = ret[7:0];
         end
         ST_WR3: begin
            mem_we = 1'b1;
            mem_addr = MEM_ADDR_BITS'({8'h01, s_ff});
            mem_wd = p_ff | 8'h10;
         end
         ST_DONE: if (cur_ff.cls == CL_RMW && (!out_valid_ff || rsp_ready)) begin
            mem_we = 1'b1;
            mem_wd = res;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wd;
      if (mem_re) rdata_ff <= mem[mem_addr];
   end

   // Datapath, evaluated in ST_DONE. Pulled bytes arrive in order in b1, b2 and then rdata.
   always_comb begin
      m = (cur_ff.beats == 2'd1) ? rdata_ff : b1_ff;
      a_in = a_ff; x_in = x_ff; y_in = y_ff; s_in = s_ff; p_in = p_ff;
      b1_in = b1_ff; b2_in = b2_ff;
      res = 8'h00;
      sum_b = (op == OP_SBC) ? ~m : m;
      sum = {1'b0, a_ff} + {1'b0, sum_b} + {8'h00, p_ff[0]};
      npc = cur_ff.req.current_pc;
      extra = 1'b0; taken = 1'b0; cond = 1'b0;
      out_in = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_RD1: b1_in = rdata_ff;
         ST_RD2: b2_in = rdata_ff;
         default: ;
      endcase
      if (state_ff == ST_IDLE && take && q_data.cls == CL_PULL) s_in = s_ff + 8'd1;
      if ((state_ff == ST_RD1 || state_ff == ST_RD2) && cur_ff.cls == CL_PULL &&
          state_in != ST_DONE) s_in = s_ff + 8'd1;
      if (state_ff == ST_WR1 || state_ff == ST_WR2 || state_ff == ST_WR3) begin
         if (cur_ff.cls == CL_PUSH) s_in = s_ff - 8'd1;
         if (state_ff == ST_WR3) p_in = p_ff | 8'h10;
      end
      if (state_ff == ST_DONE && (!out_valid_ff || rsp_ready)) begin
         unique case (op)
            OP_LDA: begin a_in = m; extra = 1'b1; end
            OP_LDX: begin x_in = m; extra = 1'b1; end
            OP_LDY: begin y_in = m; extra = 1'b1; end
            OP_TAX: x_in = a_ff;
            OP_TAY: y_in = a_ff;
            OP_TXA: a_in = x_ff;
            OP_TYA: a_in = y_ff;
            OP_TSX: x_in = s_ff;
            OP_TXS: s_in = x_ff;
            OP_PLA: a_in = m;
            OP_PLP: p_in = m;
            OP_AND: begin a_in = a_ff & m; extra = 1'b1; end
            OP_EOR: begin a_in = a_ff ^ m; extra = 1'b1; end
            OP_ORA: begin a_in = a_ff | m; extra = 1'b1; end
            OP_BIT: p_in = {m[7], m[6], p_ff[5:2], (a_ff & m) == 8'h00, p_ff[0]};
            OP_ADC, OP_SBC: begin
               a_in = sum[7:0];
               p_in[0] = sum[8];
               p_in[6] = ~(a_ff[7] ^ sum_b[7]) & (a_ff[7] ^ sum[7]);
               extra = 1'b1;
            end
            OP_CMP, OP_CPX, OP_CPY: begin
               res = (op == OP_CMP) ? a_ff : (op == OP_CPX) ? x_ff : y_ff;
               p_in[0] = res >= m;
               res = res - m;
               extra = (op == OP_CMP);
            end
            OP_INC: res = m + 8'd1;
            OP_DEC: res = m - 8'd1;
            OP_INX: x_in = x_ff + 8'd1;
            OP_INY: y_in = y_ff + 8'd1;
            OP_DEX: x_in = x_ff - 8'd1;
            OP_DEY: y_in = y_ff - 8'd1;
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
               logic [7:0] v;
               v = cur_ff.req.on_accumulator ? a_ff : m;
               unique case (op)
                  OP_ASL: begin res = {v[6:0], 1'b0}; p_in[0] = v[7]; end
                  OP_LSR: begin res = {1'b0, v[7:1]}; p_in[0] = v[0]; end
                  OP_ROL: begin res = {v[6:0], p_ff[0]}; p_in[0] = v[7]; end
                  default: begin res = {p_ff[0], v[7:1]}; p_in[0] = v[0]; end
               endcase
               if (cur_ff.req.on_accumulator) a_in = res;
            end
            OP_RTI: begin p_in = b1_ff; npc = {rdata_ff, b2_ff}; end
            OP_JMP, OP_JSR: npc = cur_ff.req.operand;
            OP_RTS: npc = {rdata_ff, b1_ff} + 16'd1;
            OP_BCC, OP_BCS, OP_BEQ, OP_BMI, OP_BNE, OP_BPL, OP_BVC, OP_BVS: begin
               unique case (op)
                  OP_BCC: cond = !p_ff[0];
                  OP_BCS: cond = p_ff[0];
                  OP_BEQ: cond = p_ff[1];
                  OP_BMI: cond = p_ff[7];
                  OP_BNE: cond = !p_ff[1];
                  OP_BPL: cond = !p_ff[7];
                  OP_BVC: cond = !p_ff[6];
                  default: cond = p_ff[6];
               endcase
               if (cond) begin
                  taken = 1'b1;
                  npc = cur_ff.req.operand;
                  extra = cur_ff.req.current_pc[15:8] != cur_ff.req.operand[15:8];
               end
            end
            OP_CLC: p_in[0] = 1'b0;
            OP_CLD: p_in[3] = 1'b0;
            OP_CLI: p_in[2] = 1'b0;
            OP_CLV: p_in[6] = 1'b0;
            OP_SEC: p_in[0] = 1'b1;
            OP_SED: p_in[3] = 1'b1;
            OP_SEI: p_in[2] = 1'b1;
            default: ;
         endcase
         // Z and N follow the value that the instruction produced.
         unique case (op)
            OP_LDA, OP_TXA, OP_TYA, OP_PLA, OP_AND, OP_EOR, OP_ORA, OP_ADC, OP_SBC:
               p_in[7:1] = {a_in[7], p_in[6:2], a_in == 8'h00};
            OP_LDX, OP_TAX, OP_TSX, OP_INX, OP_DEX:
               p_in[7:1] = {x_in[7], p_in[6:2], x_in == 8'h00};
            OP_LDY, OP_TAY, OP_INY, OP_DEY:
               p_in[7:1] = {y_in[7], p_in[6:2], y_in == 8'h00};
            OP_CMP, OP_CPX, OP_CPY, OP_INC, OP_DEC, OP_ASL, OP_LSR, OP_ROL, OP_ROR:
               p_in[7:1] = {res[7], p_in[6:2], res == 8'h00};
            default: ;
         endcase
         out_in = '{acc: a_in, x_reg: x_in, y_reg: y_in, status: p_in, stack_ptr: s_in,
                    next_pc: npc, extra_cycle: extra, branch_taken: taken};
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         a_ff <= 8'h00; x_ff <= 8'h00; y_ff <= 8'h00;
         s_ff <= 8'hFD; p_ff <= 8'h24;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         a_ff <= a_in; x_ff <= x_in; y_ff <= y_in; s_ff <= s_in; p_ff <= p_in;
      end
      if (take) cur_ff <= q_data;
      b1_ff <= b1_in;
      b2_ff <= b2_in;
      out_ff <= out_in;
   end
endmodule

/* rtl/mos6502_instruction_execute.sv */
// Top level of the 6502 instruction executor: front-end queue plus execution back end.
// Depends on m65x_pkg, m65x_front and m65x_back.

// One decoded 6502 instruction enters per req beat and yields one rsp beat carrying the
// registers, next PC and timing hints. A front queue of two entries takes new beats while the
// back end works. The back end runs each instruction through a single-port memory: register
// and flag operations go from ST_IDLE to ST_DONE, a memory access passes ST_RD1 or ST_WR1,
// and each extra stack byte pushed or pulled adds a state, up to ST_RD3 (RTI) or ST_WR3 (BRK).
// A result held in the output register does not block the next instruction from starting.
// Decimal mode is ignored; memory is not cleared at reset, so unwritten bytes read undefined.
module mos6502_instruction_execute #(
   parameter int MEM_ADDR_BITS = m65x_pkg::MemAddrBitsDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  m65x_pkg::req_type_s_type  req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output m65x_pkg::rsp_type         rsp_data
);
   import m65x_pkg::*;

   logic      q_valid, q_ready;
   entry_type q_data;

   m65x_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .q_valid, .q_ready, .q_data
   );

   m65x_back #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_back (
      .clock, .reset, .q_valid, .q_ready, .q_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("held result changed");
   a_queue_start: assert property (@(posedge clock) disable iff (reset)
      q_valid && q_ready |=> !q_ready)
      else $error("back end took two entries back to back");
endmodule
